FILE: rtl/core/ilse_pkg.sv
// ----------------------------------------------------------------------------
// ilse_pkg: shared types and constants
// Item formats, function codes and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package ilse_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int VAL_W = 32;
	localparam int FN_W  = 3;

	localparam logic [FN_W-1:0] FN_INSERT    = 3'd0;
	localparam logic [FN_W-1:0] FN_REMOVE    = 3'd1;
	localparam logic [FN_W-1:0] FN_READ      = 3'd2;
	localparam logic [FN_W-1:0] FN_OVERWRITE = 3'd3;
	localparam logic [FN_W-1:0] FN_FIND      = 3'd4;

	typedef struct packed {
		logic [FN_W-1:0]         func;
		logic [CNT_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] data;
		logic                    found;
		logic [IDX_W-1:0]        match_position;
		logic [CNT_W-1:0]        length;
		logic                    fault;
	} rsp_t;

	// broadcast to every cell
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic             wr;
		logic [CNT_W-1:0] pos;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] count;
	} cmd_t;

	// per-item status back to the result stage
	typedef struct packed {
		logic             take;
		logic             find;
		logic             fault;
		logic [CNT_W-1:0] length;
	} stat_t;

endpackage

FILE: rtl/core/indexed_list_stack_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_stack_engine: bounded ordered list in a row of cells
// Insert, remove, read, overwrite and find on a shift chain of word cells.
// ----------------------------------------------------------------------------
// Result path: the accepted request is registered in req_s1 and vld_s1, then
// the result and its strobe are registered in rsp_q and done_q.
// Throughput: one item per cycle; all cells shift and compare in parallel,
// so busy stays low and the result register never blocks a new item.
// Reset: clears the element count and the request and result strobes;
// cell contents are not reset and are only read below the count.
module indexed_list_stack_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ilse_pkg::req_t    req,
	output logic              done,
	output ilse_pkg::rsp_t    rsp
);

	ilse_pkg::req_t  req_s1;
	logic            vld_s1;
	ilse_pkg::cmd_t  cmd;
	ilse_pkg::stat_t stat;
	ilse_pkg::rsp_t  rsp_q;
	logic            done_q;

	logic [ilse_pkg::VAL_W-1:0] word  [ilse_pkg::DEPTH];
	logic [ilse_pkg::VAL_W-1:0] left  [ilse_pkg::DEPTH];
	logic [ilse_pkg::VAL_W-1:0] right [ilse_pkg::DEPTH];
	logic [ilse_pkg::DEPTH-1:0] match;
	logic                       any_hit;
	logic [ilse_pkg::IDX_W-1:0] hit_pos;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	ilse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_s1),
		.req    (req_s1),
		.cmd    (cmd),
		.stat   (stat)
	);

	always_comb begin
		for (int i = 0; i < ilse_pkg::DEPTH; i++) begin
			left[i]  = (i == 0) ? word[i] : word[(i == 0) ? 0 : i - 1];
			right[i] = (i == ilse_pkg::DEPTH - 1) ? word[i]
				: word[(i == ilse_pkg::DEPTH - 1) ? i : i + 1];
		end
	end

	genvar g;
	generate
		for (g = 0; g < ilse_pkg::DEPTH; g++) begin : g_cell
			ilse_cell u_cell (
				.clk   (clk),
				.idx   (ilse_pkg::IDX_W'(g)),
				.cmd   (cmd),
				.left  (left[g]),
				.right (right[g]),
				.word  (word[g]),
				.match (match[g])
			);
		end
	endgenerate

	// first matching position wins
	always_comb begin
		any_hit = 1'b0;
		hit_pos = '0;
		for (int i = ilse_pkg::DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				any_hit = 1'b1;
				hit_pos = ilse_pkg::IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			rsp_q.data           <= stat.take ? word[req_s1.position[ilse_pkg::IDX_W-1:0]]
				: '0;
			rsp_q.found          <= stat.find && any_hit;
			rsp_q.match_position <= (stat.find && any_hit) ? hit_pos : '0;
			rsp_q.length         <= stat.length;
			rsp_q.fault          <= stat.fault;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.length <= ilse_pkg::CNT_W'(ilse_pkg::DEPTH))
		else $error("list length above depth");

	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.fault |-> rsp.data == '0 && !rsp.found)
		else $error("faulted item carries data");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("result strobe missing");

	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) && rsp.fault |-> rsp.length == $past(rsp.length))
		else $error("fault changed the list length");

endmodule

FILE: rtl/core/ilse_cell.sv
// ----------------------------------------------------------------------------
// ilse_cell: one list slot
// Holds one word; shifts from a neighbor, loads or keeps, and compares.
// ----------------------------------------------------------------------------
module ilse_cell (
	input  logic                         clk,
	input  logic [ilse_pkg::IDX_W-1:0]   idx,
	input  ilse_pkg::cmd_t               cmd,
	input  logic [ilse_pkg::VAL_W-1:0]   left,
	input  logic [ilse_pkg::VAL_W-1:0]   right,
	output logic [ilse_pkg::VAL_W-1:0]   word,
	output logic                         match
);

	logic [ilse_pkg::VAL_W-1:0] data_q;
	logic [ilse_pkg::VAL_W-1:0] data_nxt;
	logic [ilse_pkg::CNT_W-1:0] idx_w;

	assign idx_w = {{(ilse_pkg::CNT_W - ilse_pkg::IDX_W){1'b0}}, idx};

	always_comb begin
		data_nxt = data_q;
		if (cmd.ins && idx_w > cmd.pos) begin
			data_nxt = left;
		end
		if ((cmd.ins || cmd.wr) && idx_w == cmd.pos) begin
			data_nxt = cmd.value;
		end
		if (cmd.rem && idx_w >= cmd.pos) begin
			data_nxt = right;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign word  = data_q;
	assign match = (data_q == cmd.value) && (idx_w < cmd.count);

endmodule

FILE: rtl/core/ilse_ctrl.sv
// ----------------------------------------------------------------------------
// ilse_ctrl: request decode and fill count
// Range checks, cell command broadcast and element count.
// ----------------------------------------------------------------------------
module ilse_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld,
	input  ilse_pkg::req_t     req,
	output ilse_pkg::cmd_t     cmd,
	output ilse_pkg::stat_t    stat
);

	logic [ilse_pkg::CNT_W-1:0] count_q;
	logic [ilse_pkg::CNT_W-1:0] count_nxt;
	logic is_ins, is_rem, is_rd, is_wr, is_find;
	logic in_range, ins_ok, rem_ok, empty_pop;

	assign is_ins  = vld && req.func == ilse_pkg::FN_INSERT;
	assign is_rem  = vld && req.func == ilse_pkg::FN_REMOVE;
	assign is_rd   = vld && req.func == ilse_pkg::FN_READ;
	assign is_wr   = vld && req.func == ilse_pkg::FN_OVERWRITE;
	assign is_find = vld && req.func == ilse_pkg::FN_FIND;

	assign in_range  = req.position < count_q;
	assign empty_pop = count_q == '0 && req.position == '0;
	assign ins_ok    = is_ins && count_q < ilse_pkg::CNT_W'(ilse_pkg::DEPTH)
		&& req.position <= count_q;
	assign rem_ok    = is_rem && in_range;

	always_comb begin
		count_nxt = count_q;
		if (ins_ok) begin
			count_nxt = count_q + ilse_pkg::CNT_W'(1);
		end else if (rem_ok) begin
			count_nxt = count_q - ilse_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	assign cmd.ins   = ins_ok;
	assign cmd.rem   = rem_ok;
	assign cmd.wr    = is_wr && in_range;
	assign cmd.pos   = req.position;
	assign cmd.value = req.value;
	assign cmd.count = count_q;

	assign stat.take   = rem_ok || (is_rd && in_range);
	assign stat.find   = is_find;
	assign stat.fault  = (is_ins && !ins_ok) || (is_rem && !in_range && !empty_pop)
		|| ((is_rd || is_wr) && !in_range);
	assign stat.length = count_nxt;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for indexed_list_stack_engine
// Drives list requests through the start/busy handshake in random bursts,
// predicts each result from a local copy of the list and checks every
// result strobe, field by field, in order.
// ----------------------------------------------------------------------------
module tb;
	import ilse_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	logic signed [VAL_W-1:0] list_cells [DEPTH];
	int list_len = 0;
	rsp_t pending_rsp [$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	bit pacing = 1'b1;

	always #1 clk = ~clk;

	indexed_list_stack_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic req_t mk_req(input logic [FN_W-1:0] fn, input int pos,
			input logic signed [VAL_W-1:0] val);
		req_t it;
		it.func = fn;
		it.position = CNT_W'(pos);
		it.value = val;
		return it;
	endfunction

	// apply one request to the local list and return its result
	function automatic rsp_t predict_list_op(input req_t it);
		rsp_t r;
		int pos;
		int i;
		r = '0;
		pos = int'(it.position);
		case (it.func)
			FN_INSERT: begin
				if (list_len >= DEPTH || pos > list_len) begin
					r.fault = 1'b1;
				end else begin
					for (i = list_len; i > pos; i--)
						list_cells[i] = list_cells[i-1];
					list_cells[pos] = it.value;
					list_len++;
				end
			end
			FN_REMOVE: begin
				if (pos >= list_len && !(list_len == 0 && pos == 0)) begin
					r.fault = 1'b1;
				end else if (list_len != 0) begin
					r.data = list_cells[pos];
					for (i = pos; i + 1 < list_len; i++)
						list_cells[i] = list_cells[i+1];
					list_len--;
				end
			end
			FN_READ: begin
				if (pos >= list_len)
					r.fault = 1'b1;
				else
					r.data = list_cells[pos];
			end
			FN_OVERWRITE: begin
				if (pos >= list_len)
					r.fault = 1'b1;
				else
					list_cells[pos] = it.value;
			end
			FN_FIND: begin
				for (i = 0; i < list_len; i++) begin
					if (list_cells[i] == it.value) begin
						r.found = 1'b1;
						r.match_position = IDX_W'(i);
						break;
					end
				end
			end
			default: ;
		endcase
		r.length = CNT_W'(list_len);
		return r;
	endfunction

	always @(negedge clk) begin
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected result: data %0d length %0d", rsp.data, rsp.length);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.data !== want.data) begin
					$error("data: expected %0d, got %0d", want.data, rsp.data);
					errors++;
				end
				if (rsp.found !== want.found) begin
					$error("found: expected %0b, got %0b", want.found, rsp.found);
					errors++;
				end
				if (rsp.match_position !== want.match_position) begin
					$error("match_position: expected %0d, got %0d",
						want.match_position, rsp.match_position);
					errors++;
				end
				if (rsp.length !== want.length) begin
					$error("length: expected %0d, got %0d", want.length, rsp.length);
					errors++;
				end
				if (rsp.fault !== want.fault) begin
					$error("fault: expected %0b, got %0b", want.fault, rsp.fault);
					errors++;
				end
			end
		end
	end

	// start low; req carries noise that must be ignored
	task automatic idle_cycles(input int n);
		repeat (n) begin
			start <= 1'b0;
			req <= mk_req(FN_W'($urandom), int'($urandom_range(0, 31)), $urandom);
			@(posedge clk);
		end
	endtask

	task automatic send_item(input req_t it);
		if (pacing) begin
			if (burst_left == 0) begin
				idle_cycles($urandom_range(1, 6));
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		start <= 1'b1;
		req <= it;
		forever begin
			@(negedge clk);
			if (busy === 1'b0)
				break;
			@(posedge clk);
		end
		@(posedge clk);
		pending_rsp.push_back(predict_list_op(it));
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40 && list_len > 0)
			return list_cells[$urandom_range(0, list_len - 1)];
		if (roll < 60)
			return VAL_W'(int'($urandom_range(0, 8)) - 4);
		if (roll < 70)
			return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
		return $urandom;
	endfunction

	task automatic test_empty_list();
		send_item(mk_req(FN_REMOVE, 0, 0));
		send_item(mk_req(FN_REMOVE, 3, 0));
		send_item(mk_req(FN_READ, 0, 0));
		send_item(mk_req(FN_OVERWRITE, 0, 1));
		send_item(mk_req(FN_FIND, 0, 0));
		send_item(mk_req(FN_INSERT, 1, 5));
		send_item(mk_req(3'd5, 31, -1));
		send_item(mk_req(3'd6, 0, VAL_MAX));
		send_item(mk_req(3'd7, 16, VAL_MIN));
	endtask

	task automatic test_basic_ops();
		send_item(mk_req(FN_INSERT, 0, VAL_MAX));
		send_item(mk_req(FN_INSERT, 0, VAL_MIN));
		send_item(mk_req(FN_INSERT, 2, -1));
		send_item(mk_req(FN_INSERT, 1, 0));
		send_item(mk_req(FN_READ, 0, 0));
		send_item(mk_req(FN_READ, 3, 0));
		send_item(mk_req(FN_READ, 4, 0));
		send_item(mk_req(FN_OVERWRITE, 1, 32'sh5a5a_5a5a));
		send_item(mk_req(FN_OVERWRITE, 16, 7));
		send_item(mk_req(FN_FIND, 0, -1));
		send_item(mk_req(FN_FIND, 0, 0));
		send_item(mk_req(FN_FIND, 0, 32'sh5a5a_5a5a));
		send_item(mk_req(FN_REMOVE, 31, 0));
		send_item(mk_req(FN_REMOVE, 3, 0));
		send_item(mk_req(FN_REMOVE, 0, 0));
		send_item(mk_req(FN_REMOVE, 1, 0));
		send_item(mk_req(FN_REMOVE, 0, 0));
	endtask

	// back-to-back: fill, overflow, then drain from both ends
	task automatic test_fill_and_drain();
		pacing = 1'b0;
		while (list_len < DEPTH)
			send_item(mk_req(FN_INSERT, $urandom_range(0, list_len), pick_value()));
		send_item(mk_req(FN_INSERT, 0, pick_value()));
		send_item(mk_req(FN_INSERT, list_len, pick_value()));
		send_item(mk_req(FN_INSERT, $urandom_range(0, 31), pick_value()));
		send_item(mk_req(FN_FIND, 0, list_cells[DEPTH-1]));
		while (list_len > 0)
			send_item(mk_req(FN_REMOVE, ($urandom_range(0, 1) != 0) ? 0 : list_len - 1, 0));
		send_item(mk_req(FN_REMOVE, 0, 0));
		pacing = 1'b1;
	endtask

	task automatic test_random_walk(input int n_items);
		int phase_left;
		int grow_pct;
		int roll;
		int pos;
		logic [FN_W-1:0] fn;
		phase_left = 0;
		grow_pct = 50;
		repeat (n_items) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(10, 60);
				case ($urandom_range(0, 3))
					0: grow_pct = 85;
					1: grow_pct = 15;
					default: grow_pct = 50;
				endcase
				pacing = ($urandom_range(0, 4) != 0);
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				send_item(mk_req(FN_W'($urandom), $urandom_range(0, 31), $urandom));
				continue;
			end
			if (roll < 65)
				fn = ($urandom_range(0, 99) < grow_pct) ? FN_INSERT : FN_REMOVE;
			else if (roll < 80)
				fn = FN_READ;
			else if (roll < 88)
				fn = FN_OVERWRITE;
			else
				fn = FN_FIND;
			if ($urandom_range(0, 99) < 8)
				pos = $urandom_range(0, 31);
			else if (fn == FN_INSERT)
				pos = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? list_len : 0)
					: $urandom_range(0, list_len);
			else if (list_len == 0)
				pos = 0;
			else
				pos = $urandom_range(0, list_len - 1);
			send_item(mk_req(fn, pos, pick_value()));
		end
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++)
			list_cells[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_basic_ops();
		wait_drain();
		test_fill_and_drain();
		test_random_walk(1380);
		wait_drain();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
